@@ sv/tgfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Tiled grid flip/rotate: shared package
// Field widths, opcodes, transform kinds and the transform control struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tgfr_pkg;

   localparam int MAX_LOG_SIDE_DEF = 7;
   localparam int VALUE_BITS_DEF   = 16;

   localparam int OPCODE_BITS = 2;
   localparam int COORD_BITS  = 7;
   localparam int DATA_BITS   = 16;
   localparam int KIND_BITS   = 4;
   localparam int LEVEL_BITS  = 3;
   localparam int CFG_BITS    = 3;
   localparam int LG_BITS     = 4;

   localparam logic [OPCODE_BITS-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_XFORM = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_FLIP_TB   = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_FLIP_LR   = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_ROT_CW    = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_ROT_CCW   = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_POS_TB    = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_POS_LR    = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_POS_CW    = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_POS_CCW   = 4'd8;

   localparam logic [CFG_BITS-1:0] LOG_SIDE_RESET = 3'd7;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [LEVEL_BITS-1:0] level;
      logic [LG_BITS-1:0]    lg;
   } xform_type;

endpackage

`default_nettype wire

@@ sv/tgfr_req_if.sv @@
// ----------------------------------------------------------------------------
// Tiled grid flip/rotate: request channel
// One beat is a load, read or transform command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tgfr_req_if;
   logic                              valid;
   logic                              ready;
   logic [tgfr_pkg::OPCODE_BITS-1:0]  opcode;
   logic [tgfr_pkg::COORD_BITS-1:0]   row;
   logic [tgfr_pkg::COORD_BITS-1:0]   col;
   logic [tgfr_pkg::DATA_BITS-1:0]    load_value;
   logic [tgfr_pkg::KIND_BITS-1:0]    op_kind;
   logic [tgfr_pkg::LEVEL_BITS-1:0]   block_level;

   modport source (output valid, opcode, row, col, load_value, op_kind, block_level,
                   input ready);
   modport sink   (input valid, opcode, row, col, load_value, op_kind, block_level,
                   output ready);
endinterface

`default_nettype wire

@@ sv/tgfr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Tiled grid flip/rotate: response channel
// One beat per command: read data and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tgfr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tgfr_pkg::DATA_BITS-1:0]  read_value;
   logic                            status;

   modport source (output valid, read_value, status, input ready);
   modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

@@ sv/tgfr_csr_if.sv @@
// ----------------------------------------------------------------------------
// Tiled grid flip/rotate: configuration write channel
// One beat writes log_side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tgfr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tgfr_pkg::CFG_BITS-1:0]  log_side;

   modport source (output valid, log_side, input ready);
   modport sink   (input valid, log_side, output ready);
endinterface

`default_nettype wire

@@ sv/tiled_grid_flip_rotate_top.sv @@
// ----------------------------------------------------------------------------
// Tiled grid flip/rotate: top level
// Holds a square grid of side 2^log_side in two banks, one active. Load and
// read commands go to the active bank and are taken one per cycle while no
// transform runs and no response is stalled. A transform sweeps all
// 2^(2*MAX_LOG_SIDE) entries of the active bank through its single read port,
// one per cycle, writes each to its remapped place in the other bank (entries
// outside the grid in use are copied in place), then swaps banks; it holds
// off new commands until the swap. A bad kind or level gets status 1. Read
// data goes through the bank and response registers; one response per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tiled_grid_flip_rotate_top #(
   parameter int MAX_LOG_SIDE = tgfr_pkg::MAX_LOG_SIDE_DEF,
   parameter int VALUE_BITS   = tgfr_pkg::VALUE_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   tgfr_req_if.sink   req_ch,
   tgfr_rsp_if.source rsp_ch,
   tgfr_csr_if.sink   csr_ch
);
   import tgfr_pkg::*;

   localparam int CW = MAX_LOG_SIDE;
   localparam int AW = 2 * CW;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [CFG_BITS-1:0]   log_side_ff, log_side_in;
   logic [1:0]            state_ff, state_in;
   logic                  act_ff, act_in;
   logic [AW-1:0]         walk_ff, walk_in;
   xform_type             xf_ff, xf_in;
   logic                  wr_valid_ff, wr_valid_in;
   logic [AW-1:0]         wr_addr_ff, wr_addr_in;
   logic                  p_valid_ff, p_valid_in;
   logic                  p_read_ff, p_read_in;
   logic                  p_bank_ff, p_bank_in;
   logic                  p_status_ff, p_status_in;
   logic                  o_valid_ff, o_valid_in;
   logic [DATA_BITS-1:0]  o_value_ff, o_value_in;
   logic                  o_status_ff, o_status_in;

   logic [LG_BITS-1:0]    lg_use;
   logic [CW-1:0]         smask;
   logic [AW-1:0]         req_addr, remap_addr;
   logic                  p_adv, p_free, acc, xf_bad, xf_go, item_status;
   logic                  bank_we [2];
   logic                  bank_re [2];
   logic [AW-1:0]         bank_waddr, bank_raddr;
   logic [VALUE_BITS-1:0] bank_wdata;
   logic [VALUE_BITS-1:0] bank_q [2];

   // config
   assign csr_ch.ready = 1'b1;
   assign log_side_in  = csr_ch.valid ? csr_ch.log_side : log_side_ff;
   assign lg_use = (LG_BITS'(log_side_ff) > LG_BITS'(MAX_LOG_SIDE)) ?
                   LG_BITS'(MAX_LOG_SIDE) : LG_BITS'(log_side_ff);
   assign smask  = (CW'(1) << lg_use) - CW'(1);

   assign req_addr = {CW'(req_ch.row) & smask, CW'(req_ch.col) & smask};

   // handshake
   assign p_adv        = p_valid_ff && (!o_valid_ff || rsp_ch.ready);
   assign p_free       = !p_valid_ff || p_adv;
   assign req_ch.ready = (state_ff == ST_IDLE) && p_free;
   assign acc          = req_ch.valid && req_ch.ready;
   assign xf_bad       = (req_ch.op_kind < KIND_FLIP_TB) || (req_ch.op_kind > KIND_POS_CCW) ||
                         (LG_BITS'(req_ch.block_level) > lg_use);
   assign xf_go        = acc && (req_ch.opcode == OP_XFORM) && !xf_bad;

   always_comb begin
      case (req_ch.opcode)
         OP_LOAD:  item_status = 1'b0;
         OP_READ:  item_status = 1'b0;
         OP_XFORM: item_status = 1'b1;
         default:  item_status = 1'b1;
      endcase
   end

   tgfr_remap #(.MAX_LOG_SIDE(MAX_LOG_SIDE)) u_remap (
      .src_addr (walk_ff),
      .xf       (xf_ff),
      .dst_addr (remap_addr)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      walk_in     = walk_ff;
      xf_in       = xf_ff;
      wr_valid_in = (state_ff == ST_WALK);
      wr_addr_in  = remap_addr;
      p_valid_in  = p_adv ? 1'b0 : p_valid_ff;
      p_read_in   = p_read_ff;
      p_bank_in   = p_bank_ff;
      p_status_in = p_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (xf_go) begin
               state_in = ST_WALK;
               walk_in  = '0;
               xf_in    = '{kind: req_ch.op_kind, level: req_ch.block_level, lg: lg_use};
            end else if (acc) begin
               p_valid_in  = 1'b1;
               p_read_in   = (req_ch.opcode == OP_READ);
               p_bank_in   = act_ff;
               p_status_in = item_status;
            end
         end
         ST_WALK: begin
            walk_in = walk_ff + AW'(1);
            if (walk_ff == '1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in    = ST_IDLE;
            act_in      = !act_ff;
            p_valid_in  = 1'b1;
            p_read_in   = 1'b0;
            p_status_in = 1'b0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // banks
   assign bank_waddr = wr_valid_ff ? wr_addr_ff : req_addr;
   assign bank_wdata = wr_valid_ff ? bank_q[act_ff] : VALUE_BITS'(req_ch.load_value);
   assign bank_raddr = (state_ff == ST_WALK) ? walk_ff : req_addr;

   for (genvar g = 0; g < 2; g++) begin : g_bank
      assign bank_we[g] = (acc && (req_ch.opcode == OP_LOAD) && (act_ff == 1'(g))) ||
                          (wr_valid_ff && (act_ff != 1'(g)));
      assign bank_re[g] = (act_ff == 1'(g)) &&
                          ((acc && (req_ch.opcode == OP_READ)) || (state_ff == ST_WALK));

      tgfr_bank #(.ADDR_BITS(AW), .WORD_BITS(VALUE_BITS)) u_bank (
         .clock (clock),
         .we    (bank_we[g]),
         .waddr (bank_waddr),
         .wdata (bank_wdata),
         .re    (bank_re[g]),
         .raddr (bank_raddr),
         .rdata (bank_q[g])
      );
   end

   // response register
   assign o_valid_in  = p_adv || (o_valid_ff && !rsp_ch.ready);
   assign o_value_in  = p_adv ? (p_read_ff ? DATA_BITS'(bank_q[p_bank_ff]) : '0) : o_value_ff;
   assign o_status_in = p_adv ? p_status_ff : o_status_ff;

   assign rsp_ch.valid      = o_valid_ff;
   assign rsp_ch.read_value = o_value_ff;
   assign rsp_ch.status     = o_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_side_ff <= LOG_SIDE_RESET;
         state_ff    <= ST_IDLE;
         act_ff      <= 1'b0;
         wr_valid_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         log_side_ff <= log_side_in;
         state_ff    <= state_in;
         act_ff      <= act_in;
         wr_valid_ff <= wr_valid_in;
         p_valid_ff  <= p_valid_in;
         o_valid_ff  <= o_valid_in;
      end
      walk_ff     <= walk_in;
      xf_ff       <= xf_in;
      wr_addr_ff  <= wr_addr_in;
      p_read_ff   <= p_read_in;
      p_bank_ff   <= p_bank_in;
      p_status_ff <= p_status_in;
      o_value_ff  <= o_value_in;
      o_status_ff <= o_status_in;
   end

`ifndef SYNTHESIS
   a_no_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !p_valid_ff)
      else $error("pending read held across a transform sweep");

   a_drain_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_IDLE) && p_valid_ff && !p_status_ff)
      else $error("transform finish did not queue a response");

   a_bank_swap: assert property (@(posedge clock) disable iff (reset)
      (act_ff != $past(act_ff)) |-> ($past(state_ff) == ST_DRAIN))
      else $error("active bank changed outside transform finish");

   a_sweep_write: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> (state_ff != ST_IDLE))
      else $error("sweep write while idle");
`endif

endmodule

`default_nettype wire

@@ sv/tgfr_bank.sv @@
// ----------------------------------------------------------------------------
// Tiled grid flip/rotate: grid bank
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgfr_bank #(
   parameter int ADDR_BITS = 2 * tgfr_pkg::MAX_LOG_SIDE_DEF,
   parameter int WORD_BITS = tgfr_pkg::VALUE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WORD_BITS-1:0] wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WORD_BITS-1:0] rdata
);

   logic [WORD_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ sv/tgfr_remap.sv @@
// ----------------------------------------------------------------------------
// Tiled grid flip/rotate: address remap
// Maps a source element address to its destination for one transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgfr_remap #(
   parameter int MAX_LOG_SIDE = tgfr_pkg::MAX_LOG_SIDE_DEF
) (
   input  logic [2*MAX_LOG_SIDE-1:0] src_addr,
   input  tgfr_pkg::xform_type       xf,
   output logic [2*MAX_LOG_SIDE-1:0] dst_addr
);
   import tgfr_pkg::*;

   localparam int CW = MAX_LOG_SIDE;

   logic [CW-1:0] r, c, side, smask, m, gap_off;
   logic [CW-1:0] i, y, j, x, dr, dc;
   logic          in_area;

   always_comb begin
      r       = src_addr[2*CW-1:CW];
      c       = src_addr[CW-1:0];
      side    = CW'(1) << xf.lg;
      smask   = side - CW'(1);
      m       = (CW'(1) << xf.level) - CW'(1);
      gap_off = side - (m + CW'(1));
      i       = r & ~m;
      y       = r & m;
      j       = c & ~m;
      x       = c & m;
      case (xf.kind)
         KIND_FLIP_TB: begin dr = i + m - y;       dc = j + x;           end
         KIND_FLIP_LR: begin dr = i + y;           dc = j + m - x;       end
         KIND_ROT_CW:  begin dr = i + x;           dc = j + m - y;       end
         KIND_ROT_CCW: begin dr = i + m - x;       dc = j + y;           end
         KIND_POS_TB:  begin dr = gap_off - i + y; dc = j + x;           end
         KIND_POS_LR:  begin dr = i + y;           dc = gap_off - j + x; end
         KIND_POS_CW:  begin dr = j + y;           dc = gap_off - i + x; end
         default:      begin dr = gap_off - j + y; dc = i + x;           end
      endcase
      in_area  = ((r & ~smask) == '0) && ((c & ~smask) == '0);
      dst_addr = in_area ? {dr & smask, dc & smask} : src_addr;
   end

endmodule

`default_nettype wire
